// ===== rtl/arpk_pkg.sv =====
// shared types and constants for the address run record packer
package arpk_pkg;

    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;
    localparam int MIN_LIMIT = 2;

    typedef enum logic [1:0] {
        ACT_DATA   = 2'd0,
        ACT_START  = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_IGNORE = 2'd3
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] address;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_record;
        logic       last;
    } result_t;

    // classified item handed from front to back
    typedef struct packed {
        action_t     op;
        logic        flush_pre;
        logic        flush_post;
        logic [31:0] address;
        logic [7:0]  data_byte;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EXEC,
        B_ADDR,
        B_LEN,
        B_DATA,
        B_SADDR,
        B_SZERO
    } back_state_t;

endpackage

// ===== rtl/arpk_fifo.sv =====
// two-entry queue used between front and back and on the result side
module arpk_fifo #(
    parameter type T = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    T           mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/arpk_front.sv =====
// front end: takes items, tracks the open run and classifies flushes
module arpk_front #(
    parameter int MAX_RUN = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  arpk_pkg::item_t               item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [arpk_pkg::CFG_W-1:0]    cfg_data,
    output logic                          cq_push,
    input  logic                          cq_full,
    output arpk_pkg::cmd_t                cq_data
);

    localparam int CW = $clog2(MAX_RUN + 1);

    logic [arpk_pkg::CFG_W-1:0] cfg_reg;
    logic [31:0]                start_reg;
    logic [31:0]                start_next;
    logic [CW-1:0]              cnt_reg;
    logic [CW-1:0]              cnt_next;

    logic          accept;
    logic [6:0]    lim;
    logic          brk;
    logic [CW-1:0] cnt_a;
    logic [31:0]   start_a;
    logic [CW-1:0] cnt_b;
    logic          post;

    assign full      = cq_full;
    assign cfg_ready = 1'b1;
    assign accept    = push & ~cq_full;

    always_comb
    begin
        lim = 7'(cfg_reg);
        if (lim < 7'(arpk_pkg::MIN_LIMIT))
        begin
            lim = 7'(arpk_pkg::MIN_LIMIT);
        end
        if (lim > 7'(MAX_RUN))
        begin
            lim = 7'(MAX_RUN);
        end
    end

    always_comb
    begin
        // address break against the open run
        brk     = (cnt_reg != '0) && (item.address != start_reg + 32'(cnt_reg));
        cnt_a   = brk ? '0 : cnt_reg;
        start_a = (cnt_a == '0) ? item.address : start_reg;
        cnt_b   = CW'(cnt_a + 1'b1);
        post    = (7'(cnt_b) >= lim);

        cnt_next   = cnt_reg;
        start_next = start_reg;
        cq_push    = 1'b0;

        cq_data.op         = item.action;
        cq_data.flush_pre  = brk;
        cq_data.flush_post = post;
        cq_data.address    = item.address;
        cq_data.data_byte  = item.data_byte;

        unique case (item.action)
            arpk_pkg::ACT_DATA:
            begin
                cq_push = accept;
                if (accept)
                begin
                    if (post)
                    begin
                        cnt_next   = '0;
                        start_next = '0;
                    end
                    else
                    begin
                        cnt_next   = cnt_b;
                        start_next = start_a;
                    end
                end
            end
            arpk_pkg::ACT_START:
            begin
                cq_push = accept;
                if (accept)
                begin
                    cnt_next   = '0;
                    start_next = '0;
                end
            end
            arpk_pkg::ACT_FLUSH:
            begin
                // empty run flush produces nothing
                cq_push = accept && (cnt_reg != '0);
                if (accept)
                begin
                    cnt_next   = '0;
                    start_next = '0;
                end
            end
            arpk_pkg::ACT_IGNORE:
            begin
                cq_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= arpk_pkg::CFG_RESET;
            start_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/arpk_back.sv =====
// back end: holds run bytes and plays out records one byte per cycle while the result queue has room
module arpk_back #(
    parameter int MAX_RUN = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cq_empty,
    input  arpk_pkg::cmd_t    cq_data,
    output logic              cq_pop,
    input  logic              oq_full,
    output logic              oq_push,
    output arpk_pkg::result_t oq_data
);

    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int IW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    arpk_pkg::back_state_t state_reg;
    arpk_pkg::back_state_t state_next;
    arpk_pkg::cmd_t        cmd_reg;
    arpk_pkg::cmd_t        cmd_next;
    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         idx_next;
    logic [CW-1:0]         bcnt_reg;
    logic [CW-1:0]         bcnt_next;
    logic [31:0]           bstart_reg;
    logic [31:0]           bstart_next;
    logic                  ret_idle_reg;
    logic                  ret_idle_next;
    logic [7:0]            rd_data_reg;

    logic [7:0]    mem [MAX_RUN];
    logic          mem_we;
    logic [IW-1:0] rd_addr;
    logic          last_flush;
    logic          fin;
    logic          emit;

    function automatic logic [7:0] addr_byte(input logic [31:0] a, input logic [1:0] i);
        logic [7:0] b;
        unique case (i)
            2'd0: b = a[31:24];
            2'd1: b = a[23:16];
            2'd2: b = a[15:8];
            2'd3: b = a[7:0];
        endcase
        return b;
    endfunction

    assign emit    = ~oq_full;
    assign fin     = (idx_reg == CW'(bcnt_reg - 1'b1));
    // final byte of a flush ends the item unless a further record follows
    assign last_flush = ret_idle_reg |
                        ((cmd_reg.op == arpk_pkg::ACT_DATA) && !cmd_reg.flush_post);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        bcnt_next     = bcnt_reg;
        bstart_next   = bstart_reg;
        ret_idle_next = ret_idle_reg;
        cq_pop        = 1'b0;
        oq_push       = 1'b0;
        oq_data       = '0;
        mem_we        = 1'b0;
        rd_addr       = idx_reg[IW-1:0];

        unique case (state_reg)
            arpk_pkg::B_IDLE:
            begin
                if (!cq_empty)
                begin
                    cq_pop     = 1'b1;
                    cmd_next   = cq_data;
                    state_next = arpk_pkg::B_EXEC;
                end
            end
            arpk_pkg::B_EXEC:
            begin
                idx_next = '0;
                unique case (cmd_reg.op)
                    arpk_pkg::ACT_DATA:
                    begin
                        if (cmd_reg.flush_pre)
                        begin
                            cmd_next.flush_pre = 1'b0;
                            ret_idle_next      = 1'b0;
                            state_next         = arpk_pkg::B_ADDR;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            if (bcnt_reg == '0)
                            begin
                                bstart_next = cmd_reg.address;
                            end
                            bcnt_next = CW'(bcnt_reg + 1'b1);
                            if (cmd_reg.flush_post)
                            begin
                                ret_idle_next = 1'b1;
                                state_next    = arpk_pkg::B_ADDR;
                            end
                            else
                            begin
                                state_next = arpk_pkg::B_IDLE;
                            end
                        end
                    end
                    arpk_pkg::ACT_START:
                    begin
                        if (bcnt_reg != '0)
                        begin
                            ret_idle_next = 1'b0;
                            state_next    = arpk_pkg::B_ADDR;
                        end
                        else
                        begin
                            state_next = arpk_pkg::B_SADDR;
                        end
                    end
                    arpk_pkg::ACT_FLUSH:
                    begin
                        if (bcnt_reg != '0)
                        begin
                            ret_idle_next = 1'b1;
                            state_next    = arpk_pkg::B_ADDR;
                        end
                        else
                        begin
                            state_next = arpk_pkg::B_IDLE;
                        end
                    end
                    arpk_pkg::ACT_IGNORE:
                    begin
                        state_next = arpk_pkg::B_IDLE;
                    end
                endcase
            end
            arpk_pkg::B_ADDR:
            begin
                oq_push          = emit;
                oq_data.out_byte = addr_byte(bstart_reg, idx_reg[1:0]);
                if (emit)
                begin
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        idx_next   = '0;
                        state_next = arpk_pkg::B_LEN;
                    end
                    else
                    begin
                        idx_next = CW'(idx_reg + 1'b1);
                    end
                end
            end
            arpk_pkg::B_LEN:
            begin
                // prefetch the first run byte
                rd_addr          = '0;
                oq_push          = emit;
                oq_data.out_byte = 8'(bcnt_reg);
                if (emit)
                begin
                    idx_next   = '0;
                    state_next = arpk_pkg::B_DATA;
                end
            end
            arpk_pkg::B_DATA:
            begin
                oq_push               = emit;
                oq_data.out_byte      = rd_data_reg;
                oq_data.end_of_record = fin;
                oq_data.last          = fin & last_flush;
                if (emit)
                begin
                    rd_addr = IW'(idx_reg + 1'b1);
                    if (fin)
                    begin
                        bcnt_next   = '0;
                        bstart_next = '0;
                        state_next  = ret_idle_reg ? arpk_pkg::B_IDLE : arpk_pkg::B_EXEC;
                    end
                    else
                    begin
                        idx_next = CW'(idx_reg + 1'b1);
                    end
                end
            end
            arpk_pkg::B_SADDR:
            begin
                oq_push          = emit;
                oq_data.out_byte = addr_byte(cmd_reg.address, idx_reg[1:0]);
                if (emit)
                begin
                    if (idx_reg[1:0] == 2'd3)
                    begin
                        idx_next   = '0;
                        state_next = arpk_pkg::B_SZERO;
                    end
                    else
                    begin
                        idx_next = CW'(idx_reg + 1'b1);
                    end
                end
            end
            arpk_pkg::B_SZERO:
            begin
                oq_push               = emit;
                oq_data.out_byte      = 8'd0;
                oq_data.end_of_record = 1'b1;
                oq_data.last          = 1'b1;
                if (emit)
                begin
                    state_next = arpk_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = arpk_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[bcnt_reg[IW-1:0]] <= cmd_reg.data_byte;
        end
        rd_data_reg <= mem[rd_addr];
        cmd_reg     <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= arpk_pkg::B_IDLE;
            idx_reg      <= '0;
            bcnt_reg     <= '0;
            bstart_reg   <= '0;
            ret_idle_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            bcnt_reg     <= bcnt_next;
            bstart_reg   <= bstart_next;
            ret_idle_reg <= ret_idle_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arpk_pkg::B_IDLE) |-> (bcnt_reg < CW'(MAX_RUN)))
        else $error("run count reached the buffer depth while idle");

    a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arpk_pkg::B_DATA) |-> (idx_reg < bcnt_reg))
        else $error("run byte index beyond run length");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_push && (state_reg == arpk_pkg::B_DATA) && oq_data.end_of_record)
        |=> (bcnt_reg == '0))
        else $error("run not cleared after record end");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arpk_pkg::B_LEN) |-> (bcnt_reg != '0))
        else $error("record started for an empty run");

endmodule

// ===== rtl/address_run_record_packer_top.sv =====
// Address run record packer: packs consecutive-address bytes into binary records.
//
// Items go in through push/full: a transfer happens when push is high and full is low.
// A data item extends the open run or, on an address break, first closes it; a run also
// closes when it reaches the max_record_bytes limit (clamped to 2..MAX_RUN), on a flush
// item and before a start-address item. Each record comes out as four address bytes,
// most significant first, a length byte and the run bytes, end_of_record on the final
// one; a start-address item adds its own address and a zero length byte. last marks
// the final result byte caused by one item. Results leave through empty/pop.
// The front classifies items into a two-entry command queue at one per cycle while
// that queue is not full. The back pops a command in its idle state, runs it in its
// exec state, then emits one result byte per cycle while the result queue has room;
// it pops the next command only once the current one is done.
// cfg_valid/cfg_ready writes max_record_bytes, always ready; write only while idle.
// Reset empties the run and both queues and sets the limit to 32; run bytes are not
// cleared. When pop stays low the result queue fills, the back holds, the command
// queue fills and full rises.
module address_run_record_packer_top #(
    parameter int MAX_RUN = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  arpk_pkg::item_t            item,
    output logic                       empty,
    input  logic                       pop,
    output arpk_pkg::result_t          result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [arpk_pkg::CFG_W-1:0] cfg_data
);

    logic              cq_push;
    logic              cq_full;
    arpk_pkg::cmd_t    cq_wdata;
    logic              cq_pop;
    logic              cq_empty;
    arpk_pkg::cmd_t    cq_rdata;
    logic              oq_push;
    logic              oq_full;
    arpk_pkg::result_t oq_wdata;

    arpk_front #(.MAX_RUN(MAX_RUN)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cq_push   (cq_push),
        .cq_full   (cq_full),
        .cq_data   (cq_wdata)
    );

    arpk_fifo #(.T(arpk_pkg::cmd_t)) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cq_push),
        .wr_data (cq_wdata),
        .full    (cq_full),
        .rd_en   (cq_pop),
        .rd_data (cq_rdata),
        .empty   (cq_empty)
    );

    arpk_back #(.MAX_RUN(MAX_RUN)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_empty (cq_empty),
        .cq_data  (cq_rdata),
        .cq_pop   (cq_pop),
        .oq_full  (oq_full),
        .oq_push  (oq_push),
        .oq_data  (oq_wdata)
    );

    arpk_fifo #(.T(arpk_pkg::result_t)) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_push),
        .wr_data (oq_wdata),
        .full    (oq_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

// ===== tb/address_run_record_packer_top_tb.sv =====
// testbench for the address run record packer: directed and random items against a predictor
module address_run_record_packer_top_tb;

    localparam int RUN_DEPTH = 32;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD = 150;
    localparam int STALL_LIMIT = 2000;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    arpk_pkg::item_t            item;
    logic                       empty;
    logic                       pop;
    arpk_pkg::result_t          result;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [arpk_pkg::CFG_W-1:0] cfg_data;

    // predictor state
    logic [7:0]                 run_buf [RUN_DEPTH];
    logic [31:0]                run_base;
    int                         run_len;
    logic [arpk_pkg::CFG_W-1:0] limit_reg;
    arpk_pkg::result_t          expected_bytes [$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int holds_requested = 0;
    int holds_done = 0;
    bit send_gaps = 1'b1;
    bit pop_gaps = 1'b1;

    address_run_record_packer_top #(.MAX_RUN(RUN_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int effective_limit();
        int lim;
        lim = limit_reg;
        if (lim < arpk_pkg::MIN_LIMIT)
            lim = arpk_pkg::MIN_LIMIT;
        if (lim > RUN_DEPTH)
            lim = RUN_DEPTH;
        return lim;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic eor);
        arpk_pkg::result_t r;
        r.out_byte = b;
        r.end_of_record = eor;
        r.last = 1'b0;
        expected_bytes.push_back(r);
    endfunction

    function automatic void emit_address(input logic [31:0] a);
        emit_byte(a[31:24], 1'b0);
        emit_byte(a[23:16], 1'b0);
        emit_byte(a[15:8], 1'b0);
        emit_byte(a[7:0], 1'b0);
    endfunction

    function automatic void close_run();
        int j;
        if (run_len == 0)
            return;
        emit_address(run_base);
        emit_byte(8'(run_len), 1'b0);
        for (j = 0; j < run_len; j++)
            emit_byte(run_buf[j], j == run_len - 1);
        run_base = '0;
        run_len = 0;
    endfunction

    function automatic void model_item(input arpk_pkg::item_t it);
        int prior_count;
        prior_count = expected_bytes.size();
        case (it.action)
            arpk_pkg::ACT_DATA:
            begin
                // next address wraps modulo 2^32
                if (run_len > 0 && it.address != run_base + 32'(run_len))
                    close_run();
                if (run_len == 0)
                    run_base = it.address;
                if (run_len < RUN_DEPTH)
                begin
                    run_buf[run_len] = it.data_byte;
                    run_len++;
                end
                if (run_len >= effective_limit())
                    close_run();
            end
            arpk_pkg::ACT_START:
            begin
                close_run();
                emit_address(it.address);
                emit_byte(8'h00, 1'b1);
            end
            arpk_pkg::ACT_FLUSH:
                close_run();
            default:
                ;
        endcase
        if (expected_bytes.size() > prior_count)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    task automatic push_item(input arpk_pkg::action_t act, input logic [31:0] addr,
                             input logic [7:0] data);
        arpk_pkg::item_t it;
        it.action = act;
        it.address = addr;
        it.data_byte = data;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        model_item(it);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        // an item that emits nothing may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [arpk_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    task automatic test_record_forms();
        push_item(arpk_pkg::ACT_DATA, 32'h1234_5678, 8'h00);
        push_item(arpk_pkg::ACT_DATA, 32'h1234_5679, 8'hFF);
        push_item(arpk_pkg::ACT_DATA, 32'h1234_567A, 8'hA5);
        // address break closes the open run
        push_item(arpk_pkg::ACT_DATA, 32'h0000_0000, 8'h5A);
        push_item(arpk_pkg::ACT_FLUSH, 32'h0000_0000, 8'h00);
        // flush with nothing held
        push_item(arpk_pkg::ACT_FLUSH, 32'hFFFF_FFFF, 8'hFF);
        push_item(arpk_pkg::ACT_IGNORE, 32'hFFFF_FFFF, 8'hFF);
        // run crosses the address wrap
        push_item(arpk_pkg::ACT_DATA, 32'hFFFF_FFFE, 8'h11);
        push_item(arpk_pkg::ACT_DATA, 32'hFFFF_FFFF, 8'h22);
        push_item(arpk_pkg::ACT_DATA, 32'h0000_0000, 8'h33);
        push_item(arpk_pkg::ACT_START, 32'hFFFF_FFFF, 8'h00);
        push_item(arpk_pkg::ACT_START, 32'h0000_0000, 8'hFF);
    endtask

    task automatic test_limit_register();
        int i;
        wait_drained();
        // below the minimum acts as two
        write_limit(6'd0);
        push_item(arpk_pkg::ACT_DATA, 32'h0000_0080, 8'h01);
        push_item(arpk_pkg::ACT_DATA, 32'h0000_0081, 8'h02);
        push_item(arpk_pkg::ACT_DATA, 32'h0000_0082, 8'h03);
        push_item(arpk_pkg::ACT_FLUSH, 32'h0000_0000, 8'h00);
        wait_drained();
        write_limit(6'd63);
        for (i = 0; i < 5; i++)
            push_item(arpk_pkg::ACT_DATA, 32'h0000_0200 + 32'(i), 8'(8'h40 + i));
        wait_drained();
        // limit lowered under an open run: the next byte closes it
        write_limit(6'd3);
        push_item(arpk_pkg::ACT_DATA, 32'h0000_0205, 8'h45);
        wait_drained();
        write_limit(arpk_pkg::CFG_RESET);
    endtask

    task automatic test_backpressure();
        int i;
        wait_drained();
        // receiver holds off while items keep coming, so the input stalls
        holds_requested <= holds_requested + 1;
        for (i = 0; i < 12; i++)
        begin
            push_item(arpk_pkg::ACT_DATA, 32'h0000_1000 + 32'(i), 8'($urandom));
            push_item(arpk_pkg::ACT_START, $urandom, 8'($urandom));
        end
        wait_drained();
    endtask

    task automatic random_runs(input int count);
        int sent;
        int len;
        int pick;
        int j;
        logic [31:0] addr;
        sent = 0;
        addr = $urandom;
        while (sent < count)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                addr = 32'hFFFF_FFFF - $urandom_range(0, 4);
            else if (pick < 3)
                addr = $urandom;
            // otherwise carry on from where the last run stopped
            len = $urandom_range(1, effective_limit() + 3);
            for (j = 0; j < len && sent < count; j++)
            begin
                push_item(arpk_pkg::ACT_DATA, addr, 8'($urandom));
                addr++;
                sent++;
            end
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1:
                begin
                    push_item(arpk_pkg::ACT_START, $urandom, 8'($urandom));
                    sent++;
                end
                2, 3:
                begin
                    push_item(arpk_pkg::ACT_FLUSH, $urandom, 8'($urandom));
                    sent++;
                end
                4:
                    push_item(arpk_pkg::ACT_IGNORE, $urandom, 8'($urandom));
                5:
                begin
                    push_item(arpk_pkg::ACT_DATA, $urandom, 8'($urandom));
                    sent++;
                end
                default:
                    ;
            endcase
        end
    endtask

    task automatic test_random_traffic();
        logic [arpk_pkg::CFG_W-1:0] phase_limit [5];
        int p;
        phase_limit[0] = 6'd1;
        phase_limit[1] = 6'd63;
        phase_limit[2] = 6'($urandom_range(3, 31));
        phase_limit[3] = 6'd2;
        phase_limit[4] = 6'd33;
        for (p = 0; p < 5; p++)
        begin
            wait_drained();
            write_limit(phase_limit[p]);
            random_runs(28);
        end
        wait_drained();
        write_limit(6'd32);
        send_gaps = 1'b0;
        pop_gaps <= 1'b0;
        random_runs(24);
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        run_base = '0;
        run_len = 0;
        limit_reg = arpk_pkg::CFG_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_record_forms();
        test_limit_register();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side: random stalls, plus the long hold when one is requested
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_requested)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                holds_done++;
            end
            else if (pop_gaps && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // outputs are stable mid-cycle, so check the transfer due at the next rising edge
    always @(negedge clk)
    begin : check_result
        arpk_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte: expected no result, got %0h", result.out_byte);
                mismatches++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (result.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, result.out_byte);
                    mismatches++;
                end
                if (result.end_of_record !== want.end_of_record)
                begin
                    $error("end_of_record: expected %0b, got %0b", want.end_of_record,
                        result.end_of_record);
                    mismatches++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, result.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
